// ----- rtl/dqhc_pkg.sv -----
// shared types and constants for the dns query hijack classifier
`default_nettype none

package dqhc_pkg;

   localparam int HEADER_BYTES = 12;
   localparam int ANSWER_BYTES = 16;
   localparam int LEN_OUT_W = 10;
   localparam logic [15:0] FLAGS_REDIRECT = 16'h8180;
   localparam logic [15:0] FLAGS_NOTFOUND = 16'h8403;
   localparam logic [7:0] QR_MASK = 8'h80;
   localparam logic [15:0] QTYPE_A = 16'h0001;

   typedef enum logic [1:0] {
      ACT_BYTE     = 2'd0,
      ACT_ALLOW    = 2'd1,
      ACT_DISALLOW = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      VERDICT_DROP     = 2'd0,
      VERDICT_FORWARD  = 2'd1,
      VERDICT_REDIRECT = 2'd2,
      VERDICT_NOTFOUND = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      OP_LOOKUP   = 2'd0,
      OP_ALLOW    = 2'd1,
      OP_DISALLOW = 2'd2
   } tbl_op_type;

   typedef enum logic [1:0] {
      TBL_IDLE    = 2'd0,
      TBL_SEARCH  = 2'd1,
      TBL_RESOLVE = 2'd2,
      TBL_MOVE    = 2'd3
   } tbl_state_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] client_address;
   } req_payload_type;

   typedef struct packed {
      verdict_type           verdict;
      logic [LEN_OUT_W-1:0]  request_length;
      logic [LEN_OUT_W-1:0]  response_length;
      logic [15:0]           query_type;
      logic [15:0]           transaction_id;
      logic [15:0]           response_flags;
      logic                  answer_count;
   } rsp_payload_type;

   typedef struct packed {
      logic                  ok;
      logic [LEN_OUT_W-1:0]  req_len;
      logic [15:0]           qtype;
      logic [15:0]           txid;
   } summary_type;

   typedef struct packed {
      logic        start;
      tbl_op_type  op;
      logic [31:0] key;
   } tbl_cmd_type;

   typedef struct packed {
      logic done;
      logic found;
   } tbl_result_type;

endpackage

`default_nettype wire

// ----- rtl/dqhc_parser.sv -----
// on-the-fly parser of dns request header and question section
`default_nettype none

module dqhc_parser
   import dqhc_pkg::*;
#(
   parameter int MAX_PACKET = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        take,
   input  wire logic [7:0]  data_byte,
   input  wire logic        last_byte,
   output summary_type      summary
);

   localparam int POS_W = $clog2(MAX_PACKET + 1);
   localparam int NLP_W = $clog2(MAX_PACKET + 257);
   localparam int QE_W  = $clog2(MAX_PACKET);
   localparam int LEN_W = $clog2(MAX_PACKET + 6);

   logic [POS_W-1:0] pos_ff, pos_in, pos_upd;
   logic [NLP_W-1:0] nlp_ff, nlp_in, nlp_upd;
   logic             qfound_ff, qfound_in, qfound_upd;
   logic [QE_W-1:0]  qend_ff, qend_in, qend_upd;
   logic [15:0]      type_ff, type_in, type_upd;
   logic [15:0]      id_ff, id_in, id_upd;
   logic [1:0]       hc_ff, hc_in, hc_upd;
   logic [LEN_W-1:0] qend_len;
   logic             ok;

   always_comb begin
      pos_upd    = pos_ff;
      nlp_upd    = nlp_ff;
      qfound_upd = qfound_ff;
      qend_upd   = qend_ff;
      type_upd   = type_ff;
      id_upd     = id_ff;
      hc_upd     = hc_ff;
      if (take && (pos_ff < POS_W'(MAX_PACKET))) begin
         if (pos_ff == POS_W'(0)) begin
            id_upd = {data_byte, 8'h00};
         end else if (pos_ff == POS_W'(1)) begin
            id_upd = {id_ff[15:8], data_byte};
         end else if (pos_ff == POS_W'(2)) begin
            if ((data_byte & QR_MASK) != 8'h00) begin
               hc_upd[0] = 1'b1;
            end
         end else if ((pos_ff == POS_W'(4)) || (pos_ff == POS_W'(5))) begin
            if (data_byte != 8'h00) begin
               hc_upd[1] = 1'b1;
            end
         end
         if (pos_ff >= POS_W'(HEADER_BYTES)) begin
            if (!qfound_ff) begin
               if (NLP_W'(pos_ff) == nlp_ff) begin
                  if (data_byte == 8'h00) begin
                     qfound_upd = 1'b1;
                     qend_upd   = QE_W'(pos_ff);
                  end else begin
                     nlp_upd = NLP_W'(pos_ff) + NLP_W'(data_byte) + NLP_W'(1);
                  end
               end
            end else if (LEN_W'(pos_ff) == LEN_W'(qend_ff) + LEN_W'(1)) begin
               type_upd = {data_byte, 8'h00};
            end else if (LEN_W'(pos_ff) == LEN_W'(qend_ff) + LEN_W'(2)) begin
               type_upd = {type_ff[15:8], data_byte};
            end
         end
         pos_upd = pos_ff + POS_W'(1);
      end
   end

   always_comb begin
      qend_len = LEN_W'(qend_upd) + LEN_W'(5);
      ok = (pos_upd >= POS_W'(HEADER_BYTES)) && !hc_upd[0] && hc_upd[1] && qfound_upd
           && (qend_len <= LEN_W'(pos_upd));
      summary.ok      = ok;
      summary.req_len = ok ? LEN_OUT_W'(qend_len) : '0;
      summary.qtype   = ok ? type_upd : 16'h0000;
      summary.txid    = ok ? id_upd : 16'h0000;
   end

   always_comb begin
      if (take && last_byte) begin
         pos_in    = '0;
         nlp_in    = NLP_W'(HEADER_BYTES);
         qfound_in = 1'b0;
         qend_in   = '0;
         type_in   = 16'h0000;
         id_in     = 16'h0000;
         hc_in     = 2'b00;
      end else begin
         pos_in    = pos_upd;
         nlp_in    = nlp_upd;
         qfound_in = qfound_upd;
         qend_in   = qend_upd;
         type_in   = type_upd;
         id_in     = id_upd;
         hc_in     = hc_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         nlp_ff    <= NLP_W'(HEADER_BYTES);
         qfound_ff <= 1'b0;
         qend_ff   <= '0;
         type_ff   <= 16'h0000;
         id_ff     <= 16'h0000;
         hc_ff     <= 2'b00;
      end else begin
         pos_ff    <= pos_in;
         nlp_ff    <= nlp_in;
         qfound_ff <= qfound_in;
         qend_ff   <= qend_in;
         type_ff   <= type_in;
         id_ff     <= id_in;
         hc_ff     <= hc_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/dqhc_table.sv -----
// allowed address memory with search, insert and swap-remove sequencer
`default_nettype none

module dqhc_table
   import dqhc_pkg::*;
#(
   parameter int ALLOWED_ENTRIES = 10
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire tbl_cmd_type cmd,
   input  wire logic    resp_free,
   output logic         busy,
   output tbl_result_type result
);

   localparam int CNT_W = $clog2(ALLOWED_ENTRIES + 1);
   localparam int IDX_W = (ALLOWED_ENTRIES > 1) ? $clog2(ALLOWED_ENTRIES) : 1;

   tbl_state_type    state_ff, state_in;
   tbl_op_type       op_ff, op_in;
   logic [31:0]      key_ff, key_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;
   logic [31:0]      rd_data_ff;
   logic [31:0]      mem [ALLOWED_ENTRIES];

   logic             issue;
   logic             hit;
   logic             room;
   logic [CNT_W-1:0] count_m1;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_data;

   assign issue    = idx_ff < count_ff;
   assign hit      = cmp_valid_ff && (rd_data_ff == key_ff);
   assign room     = count_ff < CNT_W'(ALLOWED_ENTRIES);
   assign count_m1 = count_ff - CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TBL_IDLE: begin
            if (cmd.start) begin
               state_in = TBL_SEARCH;
            end
         end
         TBL_SEARCH: begin
            if (!issue) begin
               state_in = TBL_RESOLVE;
            end
         end
         TBL_RESOLVE: begin
            case (op_ff)
               OP_LOOKUP: begin
                  if (resp_free) begin
                     state_in = TBL_IDLE;
                  end
               end
               OP_DISALLOW: begin
                  state_in = found_ff ? TBL_MOVE : TBL_IDLE;
               end
               default: begin
                  state_in = TBL_IDLE;
               end
            endcase
         end
         TBL_MOVE: begin
            state_in = TBL_IDLE;
         end
         default: begin
            state_in = TBL_IDLE;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      case (state_ff)
         TBL_IDLE: begin
            if (cmd.start) begin
               op_in    = cmd.op;
               key_in   = cmd.key;
               idx_in   = '0;
               found_in = 1'b0;
            end
         end
         TBL_SEARCH: begin
            if (hit && !found_ff) begin
               found_in     = 1'b1;
               found_idx_in = cmp_idx_ff;
            end
            if (issue) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = idx_ff[IDX_W-1:0];
               idx_in       = idx_ff + CNT_W'(1);
            end
         end
         TBL_RESOLVE: begin
            if ((op_ff == OP_ALLOW) && !found_ff && room) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         TBL_MOVE: begin
            count_in = count_m1;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // memory controls and outputs
   always_comb begin
      rd_en         = 1'b0;
      rd_addr       = idx_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = key_ff;
      result.done   = 1'b0;
      result.found  = found_ff;
      busy          = state_ff != TBL_IDLE;
      case (state_ff)
         TBL_SEARCH: begin
            rd_en = issue;
         end
         TBL_RESOLVE: begin
            // fetch the last entry to fill the hole
            rd_addr = count_m1[IDX_W-1:0];
            rd_en   = (op_ff == OP_DISALLOW) && found_ff;
            wr_en   = (op_ff == OP_ALLOW) && !found_ff && room;
            result.done = (op_ff == OP_LOOKUP) && resp_free;
         end
         TBL_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = found_idx_ff;
            wr_data = rd_data_ff;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TBL_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      found_idx_ff <= found_idx_in;
   end

endmodule

`default_nettype wire

// ----- rtl/dns_query_hijack_classifier_unit.sv -----
// Flow: a packet byte that is not the last is taken without a stall while the table is idle.
// On the last byte the allowed table is scanned one entry per cycle from its memory; after
// the scan and resolve states the result is registered once the output is free. Allow and
// disallow stall the input for the scan and resolve; a found disallow also moves the last entry.
// Throughput: one byte per cycle inside a packet; req_stall is high while the table is busy.
// Reset: synchronous; clears the parser, the entry count and the output valid, no table sweep.
`default_nettype none

module dns_query_hijack_classifier_unit
   import dqhc_pkg::*;
#(
   parameter int ALLOWED_ENTRIES = 10,
   parameter int MAX_PACKET = 512
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  wire req_payload_type req_payload,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            accept;
   logic            take_byte;
   logic            finish;
   logic            busy;
   logic            resp_free;
   summary_type     summary;
   summary_type     snap_ff, snap_in;
   tbl_cmd_type     cmd;
   tbl_result_type  tbl_result;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;
   assign take_byte = accept && (req_payload.action == ACT_BYTE);
   assign finish    = take_byte && req_payload.last_byte;
   assign resp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.key   = req_payload.client_address;
      cmd.start = 1'b0;
      cmd.op    = OP_LOOKUP;
      case (req_payload.action)
         ACT_BYTE: begin
            cmd.start = finish;
         end
         ACT_ALLOW: begin
            cmd.start = accept;
            cmd.op    = OP_ALLOW;
         end
         ACT_DISALLOW: begin
            cmd.start = accept;
            cmd.op    = OP_DISALLOW;
         end
         default: begin
            cmd.start = 1'b0;
         end
      endcase
   end

   dqhc_parser #(
      .MAX_PACKET(MAX_PACKET)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take_byte),
      .data_byte (req_payload.data_byte),
      .last_byte (req_payload.last_byte),
      .summary   (summary)
   );

   dqhc_table #(
      .ALLOWED_ENTRIES(ALLOWED_ENTRIES)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .resp_free (resp_free),
      .busy      (busy),
      .result    (tbl_result)
   );

   assign snap_in = finish ? summary : snap_ff;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (tbl_result.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in.verdict = VERDICT_DROP;
         if (snap_ff.ok) begin
            rsp_data_in.request_length  = snap_ff.req_len;
            rsp_data_in.response_length = snap_ff.req_len;
            rsp_data_in.query_type      = snap_ff.qtype;
            rsp_data_in.transaction_id  = snap_ff.txid;
            if (tbl_result.found) begin
               rsp_data_in.verdict = VERDICT_FORWARD;
            end else if (snap_ff.qtype == QTYPE_A) begin
               rsp_data_in.verdict         = VERDICT_REDIRECT;
               rsp_data_in.response_length = snap_ff.req_len + LEN_OUT_W'(ANSWER_BYTES);
               rsp_data_in.response_flags  = FLAGS_REDIRECT;
               rsp_data_in.answer_count    = 1'b1;
            end else begin
               rsp_data_in.verdict        = VERDICT_NOTFOUND;
               rsp_data_in.response_flags = FLAGS_NOTFOUND;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff     <= snap_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/dqhc_checker.sv -----
// port-level checker for the classifier, bound to the top level
`default_nettype none

module dqhc_checker
   import dqhc_pkg::*;
(
   input wire logic      clock,
   input wire logic      reset,
   input wire logic      req_valid,
   input wire logic      req_stall,
   input wire req_payload_type req_payload,
   input wire logic      rsp_valid,
   input wire logic      rsp_stall,
   input wire rsp_payload_type rsp_payload
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // drop carries no lengths or flags
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.verdict == VERDICT_DROP) |->
         (rsp_payload.request_length == '0) && (rsp_payload.response_length == '0)
         && (rsp_payload.response_flags == 16'h0000) && !rsp_payload.answer_count)
      else $error("drop with nonzero fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.verdict == VERDICT_REDIRECT) |->
         (rsp_payload.response_length
            == rsp_payload.request_length + LEN_OUT_W'(ANSWER_BYTES))
         && (rsp_payload.response_flags == FLAGS_REDIRECT) && rsp_payload.answer_count
         && (rsp_payload.query_type == QTYPE_A))
      else $error("malformed redirect");

   // a last byte transfer is followed by a table scan
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.action == ACT_BYTE) && req_payload.last_byte
         |=> req_stall)
      else $error("no scan after last byte");

endmodule

bind dns_query_hijack_classifier_unit dqhc_checker u_dqhc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
